// ===== rtl/sorted_score_table_core_assert.svh =====
// Assertion macros shared by the sorted score table RTL.
`ifndef SORTED_SCORE_TABLE_CORE_ASSERT_SVH
`define SORTED_SCORE_TABLE_CORE_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SST_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sst_pkg.sv =====
// Package with types and constants of the sorted score table.
`timescale 1ns / 1ps

package sst_pkg;

  // Default configuration of the table.
  localparam int TABLE_DEPTH_DEF = 32;
  localparam int NAME_BITS_DEF   = 64;

  // Fixed port widths.
  localparam int FUNC_W  = 2;
  localparam int KEY_W   = 64;
  localparam int SCORE_W = 32;

  // Operation codes of a request.
  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT = 2'd0,
    FN_REMOVE = 2'd1,
    FN_FIRST  = 2'd2,
    FN_NEXT   = 2'd3
  } func_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_INS_CHK,
    ST_INS_PUT,
    ST_REM_SCAN
  } state_t;

endpackage

// ===== rtl/sorted_score_table_core.sv =====
// Sorted score table: a descending-score list held in a single-port-write memory.
`timescale 1ns / 1ps
`include "sorted_score_table_core_assert.svh"

// The table keeps up to TABLE_DEPTH entries (name key and score) in one memory,
// ordered by descending score. A request is taken when start is high and busy is
// low; its single result appears on the out_ ports for exactly one cycle, marked
// by out_valid, and must be taken then since the receiver cannot stall. Read
// first and read next load the entry into the read register, wait in ST_RD_WAIT
// and then register the result. A request that fails at once (an insert on a
// full table, a remove or a read first on an empty table, or a read next with no
// cursor or no entry after it) answers in the cycle after acceptance. An insert
// walks the memory from the tail toward its slot, moving one entry per cycle; a
// remove walks from the head, searching and then closing the gap one entry per
// cycle. The walk runs through the memory's one read port and one write port.
// busy drops in the cycle the result is shown.
module sorted_score_table_core #(
  parameter int TABLE_DEPTH = sst_pkg::TABLE_DEPTH_DEF,
  parameter int NAME_BITS   = sst_pkg::NAME_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [sst_pkg::FUNC_W-1:0]  in_func,
  input  logic [sst_pkg::KEY_W-1:0]   in_name_key,
  input  logic [sst_pkg::SCORE_W-1:0] in_score,
  output logic                       out_valid,
  output logic                       out_success,
  output logic [sst_pkg::KEY_W-1:0]   out_name,
  output logic [sst_pkg::SCORE_W-1:0] out_score,
  output logic                       out_is_empty
);
  import sst_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int ENT_W = NAME_BITS + SCORE_W;

  // Control registers.
  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [IDX_W-1:0]   cur_idx_r, cur_idx_nxt;
  logic               cur_valid_r, cur_valid_nxt;
  logic               found_r, found_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Request and walk registers.
  logic [NAME_BITS-1:0] key_r, key_nxt;
  logic [SCORE_W-1:0]   score_r, score_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [IDX_W-1:0]     pos_r, pos_nxt;

  // Result registers.
  logic               out_success_r, out_success_nxt;
  logic [KEY_W-1:0]   out_name_r, out_name_nxt;
  logic [SCORE_W-1:0] out_score_r, out_score_nxt;
  logic               out_is_empty_r, out_is_empty_nxt;

  // Memory ports.
  logic [ENT_W-1:0] mem [TABLE_DEPTH];
  logic [ENT_W-1:0] rd_data_r;
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  logic [ENT_W-1:0] mem_wdata;

  logic                 accept;
  logic                 full;
  logic                 next_ok;
  logic                 last;
  logic                 match;
  logic                 hit;
  logic [IDX_W-1:0]     hit_pos;
  logic [NAME_BITS-1:0] rd_key;
  logic [SCORE_W-1:0]   rd_score;
  logic [ENT_W-1:0]     new_entry;

  assign accept    = start && (state_r == ST_IDLE);
  assign full      = (cnt_r == CNT_W'(TABLE_DEPTH));
  assign next_ok   = cur_valid_r && ((CNT_W'(cur_idx_r) + CNT_W'(1)) < cnt_r);
  assign last      = !((CNT_W'(idx_r) + CNT_W'(1)) < cnt_r);
  assign rd_key    = rd_data_r[ENT_W-1:SCORE_W];
  assign rd_score  = rd_data_r[SCORE_W-1:0];
  assign new_entry = {key_r, score_r};
  assign match     = (rd_key == key_r) && (rd_score == score_r);
  assign hit       = found_r || match;
  assign hit_pos   = found_r ? pos_r : idx_r;

  // Entry memory with a registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (func_t'(in_func))
            FN_INSERT: begin
              if (full) begin
                state_nxt = ST_IDLE;
              end else if (cnt_r == '0) begin
                state_nxt = ST_INS_PUT;
              end else begin
                state_nxt = ST_INS_CHK;
              end
            end
            FN_REMOVE: state_nxt = (cnt_r == '0) ? ST_IDLE : ST_REM_SCAN;
            FN_FIRST:  state_nxt = (cnt_r == '0) ? ST_IDLE : ST_RD_WAIT;
            FN_NEXT:   state_nxt = next_ok ? ST_RD_WAIT : ST_IDLE;
          endcase
        end
      end
      ST_RD_WAIT: state_nxt = ST_IDLE;
      ST_INS_CHK: begin
        if (rd_score > score_r) begin
          state_nxt = ST_IDLE;
        end else if (idx_r == '0) begin
          state_nxt = ST_INS_PUT;
        end
      end
      ST_INS_PUT:  state_nxt = ST_IDLE;
      ST_REM_SCAN: state_nxt = last ? ST_IDLE : ST_REM_SCAN;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Datapath, memory control and results.
  always_comb begin
    cnt_nxt          = cnt_r;
    cur_idx_nxt      = cur_idx_r;
    cur_valid_nxt    = cur_valid_r;
    found_nxt        = found_r;
    key_nxt          = key_r;
    score_nxt        = score_r;
    idx_nxt          = idx_r;
    pos_nxt          = pos_r;
    out_valid_nxt    = 1'b0;
    out_success_nxt  = out_success_r;
    out_name_nxt     = out_name_r;
    out_score_nxt    = out_score_r;
    out_is_empty_nxt = out_is_empty_r;
    mem_we           = 1'b0;
    mem_waddr        = '0;
    mem_wdata        = new_entry;
    mem_re           = 1'b0;
    mem_raddr        = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          key_nxt   = in_name_key[NAME_BITS-1:0];
          score_nxt = in_score;
          unique case (func_t'(in_func))
            FN_INSERT: begin
              if (full) begin
                // Full table refuses the insert.
                out_valid_nxt    = 1'b1;
                out_success_nxt  = 1'b0;
                out_name_nxt     = '0;
                out_score_nxt    = '0;
                out_is_empty_nxt = 1'b0;
              end else if (cnt_r == '0) begin
                pos_nxt = '0;
              end else begin
                // Start the walk at the tail entry.
                mem_re    = 1'b1;
                mem_raddr = IDX_W'(cnt_r - CNT_W'(1));
                idx_nxt   = IDX_W'(cnt_r - CNT_W'(1));
              end
            end
            FN_REMOVE: begin
              if (cnt_r == '0) begin
                out_valid_nxt    = 1'b1;
                out_success_nxt  = 1'b0;
                out_name_nxt     = '0;
                out_score_nxt    = '0;
                out_is_empty_nxt = 1'b1;
              end else begin
                // Start the search at the head entry.
                mem_re    = 1'b1;
                mem_raddr = '0;
                idx_nxt   = '0;
                found_nxt = 1'b0;
              end
            end
            FN_FIRST: begin
              if (cnt_r == '0) begin
                cur_valid_nxt    = 1'b0;
                out_valid_nxt    = 1'b1;
                out_success_nxt  = 1'b0;
                out_name_nxt     = '0;
                out_score_nxt    = '0;
                out_is_empty_nxt = 1'b1;
              end else begin
                cur_idx_nxt   = '0;
                cur_valid_nxt = 1'b1;
                mem_re        = 1'b1;
                mem_raddr     = '0;
              end
            end
            FN_NEXT: begin
              if (next_ok) begin
                cur_idx_nxt = cur_idx_r + IDX_W'(1);
                mem_re      = 1'b1;
                mem_raddr   = cur_idx_r + IDX_W'(1);
              end else begin
                // Past the end or no cursor: the cursor becomes empty.
                cur_valid_nxt    = 1'b0;
                out_valid_nxt    = 1'b1;
                out_success_nxt  = 1'b0;
                out_name_nxt     = '0;
                out_score_nxt    = '0;
                out_is_empty_nxt = (cnt_r == '0);
              end
            end
          endcase
        end
      end

      ST_RD_WAIT: begin
        // The entry under the cursor is now in the read register.
        out_valid_nxt    = 1'b1;
        out_success_nxt  = 1'b1;
        out_name_nxt     = KEY_W'(rd_key);
        out_score_nxt    = rd_score;
        out_is_empty_nxt = (cnt_r == '0);
      end

      ST_INS_CHK: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r + IDX_W'(1);
        if (rd_score > score_r) begin
          // The new entry goes right behind the last higher score.
          mem_wdata        = new_entry;
          cnt_nxt          = cnt_r + CNT_W'(1);
          cur_idx_nxt      = idx_r + IDX_W'(1);
          cur_valid_nxt    = 1'b1;
          out_valid_nxt    = 1'b1;
          out_success_nxt  = 1'b1;
          out_name_nxt     = '0;
          out_score_nxt    = '0;
          out_is_empty_nxt = 1'b0;
        end else begin
          // Move this entry one slot toward the tail and read the one ahead.
          mem_wdata = rd_data_r;
          if (idx_r == '0) begin
            pos_nxt = '0;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = idx_r - IDX_W'(1);
            idx_nxt   = idx_r - IDX_W'(1);
          end
        end
      end

      ST_INS_PUT: begin
        mem_we           = 1'b1;
        mem_waddr        = pos_r;
        mem_wdata        = new_entry;
        cnt_nxt          = cnt_r + CNT_W'(1);
        cur_idx_nxt      = pos_r;
        cur_valid_nxt    = 1'b1;
        out_valid_nxt    = 1'b1;
        out_success_nxt  = 1'b1;
        out_name_nxt     = '0;
        out_score_nxt    = '0;
        out_is_empty_nxt = 1'b0;
      end

      ST_REM_SCAN: begin
        // Once the match is behind us, every entry moves one slot to the head.
        if (found_r) begin
          mem_we    = 1'b1;
          mem_waddr = idx_r - IDX_W'(1);
          mem_wdata = rd_data_r;
        end else if (match) begin
          found_nxt = 1'b1;
          pos_nxt   = idx_r;
        end
        if (!last) begin
          mem_re    = 1'b1;
          mem_raddr = idx_r + IDX_W'(1);
          idx_nxt   = idx_r + IDX_W'(1);
        end else begin
          out_valid_nxt = 1'b1;
          out_name_nxt  = '0;
          out_score_nxt = '0;
          if (hit) begin
            cnt_nxt          = cnt_r - CNT_W'(1);
            out_success_nxt  = 1'b1;
            out_is_empty_nxt = (cnt_r == CNT_W'(1));
            if (cur_valid_r) begin
              if (cur_idx_r == hit_pos) begin
                cur_valid_nxt = 1'b0;
              end else if (cur_idx_r > hit_pos) begin
                cur_idx_nxt = cur_idx_r - IDX_W'(1);
              end
            end
          end else begin
            out_success_nxt  = 1'b0;
            out_is_empty_nxt = (cnt_r == '0);
          end
        end
      end

      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // Control registers with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      cur_idx_r   <= '0;
      cur_valid_r <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      cur_idx_r   <= cur_idx_nxt;
      cur_valid_r <= cur_valid_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    key_r          <= key_nxt;
    score_r        <= score_nxt;
    idx_r          <= idx_nxt;
    pos_r          <= pos_nxt;
    out_success_r  <= out_success_nxt;
    out_name_r     <= out_name_nxt;
    out_score_r    <= out_score_nxt;
    out_is_empty_r <= out_is_empty_nxt;
  end

  assign busy         = (state_r != ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_success  = out_success_r;
  assign out_name     = out_name_r;
  assign out_score    = out_score_r;
  assign out_is_empty = out_is_empty_r;

  // The fill count never passes the table depth.
  `SST_ASSERT(a_cnt_range, 1'b1, cnt_r <= CNT_W'(TABLE_DEPTH), "entry count exceeds depth")
  // A valid cursor always points at a stored entry.
  `SST_ASSERT(a_cursor_in_list, cur_valid_r, CNT_W'(cur_idx_r) < cnt_r,
              "cursor beyond the last entry")
  // The memory is only written during an insert or remove walk.
  `SST_ASSERT(a_write_busy, mem_we, state_r == ST_INS_CHK || state_r == ST_INS_PUT ||
              state_r == ST_REM_SCAN, "memory write outside a walk")
  // An accepted request either makes the core busy or answers at once.
  `SST_ASSERT_NEXT(a_accept_progress, accept, busy || out_valid,
                   "accepted request neither busy nor answered")

endmodule
